>>> rtl/tdfsm_pkg.sv
// tdfsm_pkg: shared types and constants for the table driven state machine.
// No dependencies.
`timescale 1ns / 1ps
package tdfsm_pkg;
  localparam logic [7:0] NO_STATE      = 8'd255;
  localparam logic [7:0] TIMER_RESTART = 8'd126;
  localparam logic [7:0] ELSE_TARGET   = 8'd127;
  localparam logic [7:0] CHOICE_BASE   = 8'd64;
  localparam logic [7:0] START_CODE    = 8'd249;
  localparam logic [7:0] DIRECT_MASK   = 8'h7F;

  typedef enum logic [1:0] {
    FUNC_EVENT = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_LOAD  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SEL_TRANS   = 2'd0,
    SEL_TIMEOUT = 2'd1,
    SEL_CHOICE  = 2'd2
  } sel_t;

  typedef enum logic [2:0] {
    OC_SET     = 3'd0,
    OC_RESTART = 3'd1,
    OC_NONE    = 3'd2,
    OC_ERROR   = 3'd3,
    OC_IGNORED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_START_STATE = 2'd0,
    CFG_FALLBACK    = 2'd1,
    CFG_SAME_IGNORE = 2'd2,
    CFG_START_RUN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TRANS_RD,
    S_TRANS_WAIT,
    S_RESOLVE,
    S_CH_RD,
    S_CH_WAIT,
    S_CH_EVAL,
    S_APPLY,
    S_TO_WAIT,
    S_OUT
  } state_t;

  // sequencer request into the choice evaluation unit and its answer
  typedef struct packed {
    logic [7:0]  target;
    logic [24:0] entry;
    logic        known;
    logic        value;
  } ch_req_t;

  typedef struct packed {
    logic [7:0] next;
    logic       done;
    logic       err;
  } ch_rsp_t;
endpackage

>>> rtl/tdfsm_if.sv
// tdfsm_if: valid/ready channel interfaces for input and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface tdfsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  event_code;
  logic [15:0] choice_values;
  logic [15:0] choice_known;
  logic        run_request;
  logic [1:0]  table_select;
  logic [7:0]  table_addr;
  logic [31:0] table_data;
  modport source (output valid, func, event_code, choice_values, choice_known, run_request,
                  table_select, table_addr, table_data, input ready);
  modport sink (input valid, func, event_code, choice_values, choice_known, run_request,
                table_select, table_addr, table_data, output ready);
endinterface

interface tdfsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] current_state;
  logic       running;
  logic       state_set;
  logic       timeout_fired;
  logic [2:0] outcome;
  modport source (output valid, current_state, running, state_set, timeout_fired, outcome,
                  input ready);
  modport sink (input valid, current_state, running, state_set, timeout_fired, outcome,
                output ready);
endinterface

>>> rtl/tdfsm_choice_unit.sv
// tdfsm_choice_unit: one step of choice resolution (compare and select).
// Depends on tdfsm_pkg.
`timescale 1ns / 1ps
module tdfsm_choice_unit #(
  parameter int STATE_COUNT  = 16,
  parameter int CHOICE_COUNT = 16
) (
  input  tdfsm_pkg::ch_req_t req,
  output tdfsm_pkg::ch_rsp_t rsp
);
  import tdfsm_pkg::*;

  localparam logic [7:0] CHOICE_END = 8'(64 + CHOICE_COUNT);
  logic [7:0] raw;
  logic [7:0] nx;

  always_comb begin
    if (!req.known) raw = req.entry[23:16];
    else if (req.value) raw = req.entry[7:0];
    else raw = req.entry[15:8];
    nx = raw - 8'd1;
    rsp = '{next: NO_STATE, done: 1'b1, err: 1'b0};
    if (!req.entry[24]) begin
      rsp.err = 1'b1;
    end else if (nx < 8'(STATE_COUNT)) begin
      rsp.next = nx;
    end else if (nx == ELSE_TARGET) begin
      if (req.target + 8'd1 < CHOICE_END) begin
        rsp.next = req.target + 8'd1;
        rsp.done = 1'b0;
      end else begin
        rsp.err = 1'b1;
      end
    end
  end
endmodule

>>> rtl/table_driven_fsm_with_choice_states.sv
// Table driven state machine with choice states, top level.
// Flow: decode, then as the item needs, transition table read, resolve, up to CHOICE_COUNT + 1
//   choice evaluations, apply (again when the start fallback is taken) and timeout load.
// Throughput: one item at a time; ready only in idle, in the cycle after the result is taken.
// Reset: rst synchronous, clears state to undefined, timer, run flag, config to defaults.
// Depends on tdfsm_pkg, tdfsm_if, tdfsm_choice_unit.
`timescale 1ns / 1ps
module table_driven_fsm_with_choice_states #(
  parameter int STATE_COUNT  = 16,
  parameter int CHOICE_COUNT = 16,
  parameter int SYMBOL_COUNT = 9
) (
  input logic       clk,
  input logic       rst,
  tdfsm_in_if.sink  in_ch,
  tdfsm_out_if.source out_ch,
  input logic       cfg_we,
  input logic [1:0] cfg_index,
  input logic [7:0] cfg_data
);
  import tdfsm_pkg::*;

  localparam int TRANS_DEPTH = STATE_COUNT * SYMBOL_COUNT;
  localparam int TA_W = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
  localparam int ST_W = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int CH_W = (CHOICE_COUNT > 1) ? $clog2(CHOICE_COUNT) : 1;
  localparam int CNT_W = $clog2(CHOICE_COUNT + 1);
  localparam logic [7:0] CHOICE_END = 8'(64 + CHOICE_COUNT);

  // table memories, one write and one read port each, registered read
  logic [7:0]  trans_mem [TRANS_DEPTH];
  logic [31:0] to_mem    [STATE_COUNT];
  logic [24:0] ch_mem    [CHOICE_COUNT];
  logic [7:0]  trans_q;
  logic [31:0] to_q;
  logic [24:0] ch_q;
  logic [TA_W-1:0] trans_ra;
  logic [ST_W-1:0] to_ra;
  logic [CH_W-1:0] ch_ra;

  // config
  logic [7:0] start_state, start_fallback;
  logic       same_ignore, start_run;

  // architectural state
  logic [7:0]  present_state;
  logic [31:0] active_timeout, elapsed_ms;
  logic        run_flag;

  // latched item
  logic [1:0]  func;
  logic [7:0]  code;
  logic [15:0] vals, known;
  logic        req;
  logic [1:0]  sel;
  logic [7:0]  addr;
  logic [31:0] data;

  // work registers
  state_t     state, state_next;
  logic [7:0] target;        // candidate next state / choice code
  logic [CNT_W-1:0] steps;   // choice chain length
  logic       err;
  logic       is_start;      // a start evaluation, fallback applies
  logic       fired, set_flag;
  logic [2:0] outcome;
  logic [7:0] trans_idx;
  logic       fire_now;      // tick expires the timer, judged on the updated count

  ch_req_t creq;
  ch_rsp_t crsp;

  tdfsm_choice_unit #(.STATE_COUNT(STATE_COUNT), .CHOICE_COUNT(CHOICE_COUNT)) u_choice (
    .req(creq), .rsp(crsp)
  );

  logic [7:0] cidx;
  assign cidx = target - CHOICE_BASE;
  assign creq = '{target: target, entry: ch_q, known: known[cidx[3:0]],
                  value: vals[cidx[3:0]]};
  assign trans_idx = 8'(present_state[ST_W-1:0] * SYMBOL_COUNT) + code;
  assign fire_now = run_flag && (active_timeout != 32'd0) && (elapsed_ms >= active_timeout);

  logic is_choice;
  assign is_choice = (target >= CHOICE_BASE) && (target < CHOICE_END);

  // memory writes happen while decoding a load item
  always_ff @(posedge clk) begin
    if (state == S_DECODE && func == FUNC_LOAD) begin
      if (sel == SEL_TRANS && 32'(addr) < 32'(TRANS_DEPTH))
        trans_mem[addr[TA_W-1:0]] <= data[7:0];
      if (sel == SEL_TIMEOUT && 32'(addr) < 32'(STATE_COUNT))
        to_mem[addr[ST_W-1:0]] <= data;
      if (sel == SEL_CHOICE && 32'(addr) < 32'(CHOICE_COUNT))
        ch_mem[addr[CH_W-1:0]] <= data[24:0];
    end
    trans_q <= trans_mem[trans_ra];
    to_q    <= to_mem[to_ra];
    ch_q    <= ch_mem[ch_ra];
  end

  always_comb begin
    trans_ra = 32'(trans_idx) < 32'(TRANS_DEPTH) ? trans_idx[TA_W-1:0] : '0;
    to_ra    = target[ST_W-1:0];
    ch_ra    = cidx[CH_W-1:0];
  end

  assign in_ch.ready    = (state == S_IDLE);
  assign out_ch.valid   = (state == S_OUT);
  assign out_ch.current_state = present_state;
  assign out_ch.running = run_flag;
  assign out_ch.state_set = set_flag;
  assign out_ch.timeout_fired = fired;
  assign out_ch.outcome = outcome;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= NO_STATE;
      start_fallback <= NO_STATE;
      same_ignore <= 1'b0;
      start_run <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_STATE: start_state <= cfg_data;
        CFG_FALLBACK:    start_fallback <= cfg_data;
        CFG_SAME_IGNORE: same_ignore <= cfg_data[0];
        CFG_START_RUN:   start_run <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid) state_next = S_DECODE;
      S_DECODE: begin
        state_next = S_OUT;
        if (func == FUNC_EVENT) begin
          if (code == START_CODE) state_next = S_RESOLVE;
          else if (run_flag) state_next = (present_state < 8'(STATE_COUNT) &&
                                           code < 8'(SYMBOL_COUNT)) ? S_TRANS_RD : S_RESOLVE;
        end else if (func == FUNC_TICK) begin
          state_next = S_TRANS_RD; // tick evaluation happens there
        end else if (func == FUNC_RUN) begin
          if (run_flag != req && req && present_state == NO_STATE) state_next = S_RESOLVE;
        end
      end
      S_TRANS_RD:   state_next = (func == FUNC_TICK && !fire_now) ? S_OUT : S_TRANS_WAIT;
      S_TRANS_WAIT: state_next = S_RESOLVE;
      S_RESOLVE:    state_next = is_choice ? S_CH_RD : S_APPLY;
      S_CH_RD:      state_next = S_CH_WAIT;
      S_CH_WAIT:    state_next = S_CH_EVAL;
      S_CH_EVAL:    state_next = S_RESOLVE;
      S_APPLY: begin
        if (is_start && target == NO_STATE) state_next = S_APPLY;
        else state_next = (target < 8'(STATE_COUNT)) ? S_TO_WAIT : S_OUT;
      end
      S_TO_WAIT:    state_next = S_OUT;
      S_OUT:        if (out_ch.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      present_state <= NO_STATE;
      active_timeout <= '0;
      elapsed_ms <= '0;
      run_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          func <= in_ch.func; code <= in_ch.event_code;
          vals <= in_ch.choice_values; known <= in_ch.choice_known;
          req <= in_ch.run_request; sel <= in_ch.table_select;
          addr <= in_ch.table_addr; data <= in_ch.table_data;
          fired <= 1'b0; set_flag <= 1'b0; outcome <= OC_IGNORED;
          err <= 1'b0; steps <= '0; is_start <= 1'b0;
        end
        S_DECODE: begin
          target <= NO_STATE;
          if (func == FUNC_EVENT) begin
            if (code == START_CODE) begin
              target <= start_state; is_start <= 1'b1; run_flag <= start_run;
            end else if (run_flag && present_state < 8'(STATE_COUNT) &&
                         code >= 8'(SYMBOL_COUNT) && code[7]) begin
              if ((code & DIRECT_MASK) < 8'(STATE_COUNT)) begin
                if (!((code & DIRECT_MASK) == present_state && same_ignore))
                  target <= code & DIRECT_MASK;
              end else if ((code & DIRECT_MASK) >= CHOICE_BASE &&
                           (code & DIRECT_MASK) < CHOICE_END)
                target <= code & DIRECT_MASK;
            end
          end else if (func == FUNC_TICK) begin
            code <= 8'(SYMBOL_COUNT - 1);
            if (run_flag && elapsed_ms != 32'hFFFF_FFFF) elapsed_ms <= elapsed_ms + 32'd1;
          end else if (func == FUNC_RUN) begin
            if (run_flag != req && req && present_state == NO_STATE) begin
              target <= start_state; is_start <= 1'b1;
            end
            run_flag <= req;
          end
        end
        S_TRANS_RD: begin
          // tick: decide firing on the updated timer
          if (func == FUNC_TICK) fired <= fire_now;
        end
        S_TRANS_WAIT: target <= (present_state < 8'(STATE_COUNT)) ? trans_q - 8'd1 : NO_STATE;
        S_CH_EVAL: begin
          if (32'(steps) >= 32'(CHOICE_COUNT)) begin
            err <= 1'b1; target <= NO_STATE;
          end else begin
            steps <= steps + 1'b1;
            target <= crsp.next;
            if (crsp.err) err <= 1'b1;
          end
        end
        S_APPLY: begin
          if (is_start && target == NO_STATE) target <= start_fallback;
          else if (target < 8'(STATE_COUNT)) begin
            present_state <= target; elapsed_ms <= '0;
            set_flag <= 1'b1; outcome <= OC_SET;
          end else if (target == TIMER_RESTART) begin
            elapsed_ms <= '0; outcome <= OC_RESTART;
          end else outcome <= err ? OC_ERROR : OC_NONE;
          if (is_start && target == NO_STATE) is_start <= 1'b0;
        end
        S_TO_WAIT: active_timeout <= to_q;
        default: ;
      endcase
    end
  end

  // fallback retry: S_APPLY runs a second time when a start yields no state,
  // with target rewritten to start_fallback and is_start cleared
endmodule

>>> rtl/tdfsm_checker.sv
// tdfsm_checker: port level assertions for the top level, bound in below.
// Depends on tdfsm_pkg.
`timescale 1ns / 1ps
module tdfsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       in_valid,
  input logic       out_valid,
  input logic       out_ready,
  input logic       state_set,
  input logic       timeout_fired,
  input logic [2:0] outcome,
  input logic [7:0] current_state
);
  import tdfsm_pkg::*;

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state_set == (outcome == OC_SET)))
    else $error("state_set and outcome disagree");
  a_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state_set) |-> current_state != NO_STATE)
    else $error("state set but undefined");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(outcome))
    else $error("result dropped");
  a_fire: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timeout_fired) |-> outcome != OC_IGNORED)
    else $error("fire without transfer");
endmodule

bind table_driven_fsm_with_choice_states tdfsm_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .in_valid(in_ch.valid),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .state_set(out_ch.state_set),
  .timeout_fired(out_ch.timeout_fired), .outcome(out_ch.outcome),
  .current_state(out_ch.current_state)
);
